// ===== design/ssae_pkg.sv =====
// ssae_pkg: shared types and codes of the sparse slot array engine
// request and response word layouts, request, status and shift-mode codes
// no dependencies
package ssae_pkg;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [8:0]  slot_index;
        logic [7:0]  second_index;
        logic [31:0] item_value;
        logic [1:0]  shift_mode;
        logic        compact_flag;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] item_out;
        logic [8:0]  end_marker_out;
        logic [8:0]  occupied_out;
    } rsp_t;

    localparam logic [2:0] REQ_ADD     = 3'd0;
    localparam logic [2:0] REQ_INSERT  = 3'd1;
    localparam logic [2:0] REQ_REMOVE  = 3'd2;
    localparam logic [2:0] REQ_REPLACE = 3'd3;
    localparam logic [2:0] REQ_SWAP    = 3'd4;
    localparam logic [2:0] REQ_COMPACT = 3'd5;
    localparam logic [2:0] REQ_READ    = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic [1:0] SHIFT_AUTO = 2'd0;
    localparam logic [1:0] SHIFT_HOLE = 2'd1;
    localparam logic [1:0] SHIFT_FULL = 2'd2;

    localparam int AUTO_MIN_END = 10;

endpackage

// ===== design/sparse_slot_array_engine_unit.sv =====
// sparse_slot_array_engine_unit: slot array with holes, end marker and occupied count
// one slot memory walked by a small sequencer; uses ssae_pkg
//
// channel   direction  handshake                 word
// request   in         start high, busy low      req (req_t)
// response  out        done strobe, one cycle    rsp (rsp_t)
//
// add goes from acceptance straight to S_DONE; read and replace pass S_EVAL first, swap passes
// S_EVAL, S_SWAP_EV and S_SWAP_W2; insert, remove and compact walk the slots through the one
// read port, a read state and an evaluate state per slot, and compaction (also after a remove
// with the compact flag) zeroes a vacated tail one slot per cycle
// reset clears the per-slot valid bits at once, so no clearing pass is needed
// busy stays high from acceptance through the cycle before done; the receiver cannot stall
module sparse_slot_array_engine_unit
    import ssae_pkg::*;
#(
    parameter int CAPACITY    = 256,
    parameter int ENTRY_WIDTH = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > 9) ? CW : 9;
    localparam int PW = 2 * CW;
    localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE, S_EVAL, S_SWAP_EV, S_SWAP_W2, S_DOWN_RD, S_DOWN_EV,
        S_DECIDE, S_HOLE_RD, S_HOLE_EV, S_CHECK, S_SHIFT_RD, S_SHIFT_EV,
        S_CH_RD, S_CH_EV, S_ZERO, S_DONE
    } state_t;

    // slot memory, valid bits make never-written slots read as empty
    logic [ENTRY_WIDTH-1:0] mem [CAPACITY];
    logic [CAPACITY-1:0]    vld_reg;
    logic [ENTRY_WIDTH-1:0] rdata_reg;

    logic                   mem_we;
    logic [IW-1:0]          mem_wa;
    logic [ENTRY_WIDTH-1:0] mem_wd;
    logic [IW-1:0]          mem_ra;

    state_t                 state_reg, state_next;
    logic [2:0]             op_reg, op_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          idx2_reg, idx2_next;
    logic [ENTRY_WIDTH-1:0] item_reg, item_next;
    logic [1:0]             mode_reg, mode_next;
    logic                   cflag_reg, cflag_next;
    logic [CW-1:0]          end_reg, end_next;
    logic [CW-1:0]          occ_reg, occ_next;
    logic [CW-1:0]          ptr_reg, ptr_next;
    logic [CW-1:0]          dst_reg, dst_next;
    logic [CW-1:0]          hole_reg, hole_next;
    logic [ENTRY_WIDTH-1:0] old_reg, old_next;
    logic [ENTRY_WIDTH-1:0] a_reg, a_next;
    logic [1:0]             status_reg, status_next;
    logic                   done_reg, done_next;
    rsp_t                   rsp_reg, rsp_next;

    logic [ENTRY_WIDTH-1:0] in_item;
    logic [EW-1:0]          in_idx_e, in_idx2_e, end_e;
    logic [PW-1:0]          prod;
    logic                   minimal;

    assign in_item   = ENTRY_WIDTH'(req.item_value);
    assign in_idx_e  = EW'(req.slot_index);
    assign in_idx2_e = EW'(req.second_index);
    assign end_e     = EW'(end_reg);

    // one multiply and compare for the auto shift decision
    assign prod = PW'(end_reg - occ_reg) * PW'(end_reg - idx_reg);

    always_comb
    begin
        if (end_reg == occ_reg)
            minimal = 1'b0;
        else if (mode_reg == SHIFT_HOLE)
            minimal = 1'b1;
        else if (mode_reg == SHIFT_FULL)
            minimal = 1'b0;
        else if (end_e < EW'(AUTO_MIN_END))
            minimal = 1'b0;
        else
            minimal = prod > (PW'(end_reg) << 1);
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        idx_next    = idx_reg;
        idx2_next   = idx2_reg;
        item_next   = item_reg;
        mode_next   = mode_reg;
        cflag_next  = cflag_reg;
        end_next    = end_reg;
        occ_next    = occ_reg;
        ptr_next    = ptr_reg;
        dst_next    = dst_reg;
        hole_next   = hole_reg;
        old_next    = old_reg;
        a_next      = a_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        mem_we      = 1'b0;
        mem_wa      = IW'(idx_reg);
        mem_wd      = '0;
        mem_ra      = IW'(idx_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = req.req_type;
                    idx_next    = CW'(req.slot_index);
                    idx2_next   = CW'(req.second_index);
                    item_next   = in_item;
                    mode_next   = req.shift_mode;
                    cflag_next  = req.compact_flag;
                    old_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    mem_ra      = IW'(req.slot_index);
                    case (req.req_type)
                        REQ_ADD:
                        begin
                            if (in_item == '0)
                                status_next = ST_EMPTY;
                            else if (end_e >= CAP_E)
                                status_next = ST_FULL;
                            else
                            begin
                                mem_we   = 1'b1;
                                mem_wa   = IW'(end_reg);
                                mem_wd   = in_item;
                                end_next = end_reg + 1'b1;
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (in_idx_e > end_e || req.shift_mode > SHIFT_FULL)
                                status_next = ST_BAD_INDEX;
                            else if (in_idx_e >= CAP_E)
                                status_next = ST_FULL;
                            else
                                state_next = S_EVAL;
                        end
                        REQ_REMOVE, REQ_REPLACE, REQ_READ:
                        begin
                            if (in_idx_e >= end_e)
                                status_next = ST_BAD_INDEX;
                            else
                                state_next = S_EVAL;
                        end
                        REQ_SWAP:
                        begin
                            if (in_idx_e == in_idx2_e)
                                status_next = ST_OK;
                            else if (in_idx_e >= end_e || in_idx2_e >= end_e)
                                status_next = ST_BAD_INDEX;
                            else
                                state_next = S_EVAL;
                        end
                        REQ_COMPACT:
                        begin
                            ptr_next   = '0;
                            dst_next   = '0;
                            state_next = S_CH_RD;
                        end
                        default:
                            status_next = ST_BAD_INDEX;
                    endcase
                end
            end
            // first slot read is in rdata_reg
            S_EVAL:
            begin
                state_next = S_DONE;
                case (op_reg)
                    REQ_READ:
                        old_next = rdata_reg;
                    REQ_REPLACE:
                    begin
                        old_next = rdata_reg;
                        mem_we   = 1'b1;
                        mem_wd   = item_reg;
                        if (item_reg == '0 && rdata_reg != '0)
                            occ_next = occ_reg - 1'b1;
                        else if (item_reg != '0 && rdata_reg == '0)
                            occ_next = occ_reg + 1'b1;
                    end
                    REQ_SWAP:
                    begin
                        a_next     = rdata_reg;
                        mem_ra     = IW'(idx2_reg);
                        state_next = S_SWAP_EV;
                    end
                    REQ_REMOVE:
                    begin
                        old_next = rdata_reg;
                        mem_we   = 1'b1;
                        mem_wd   = '0;
                        if (rdata_reg != '0)
                            occ_next = occ_reg - 1'b1;
                        if (idx_reg == end_reg - 1'b1)
                        begin
                            if (idx_reg == '0)
                                end_next = '0;
                            else
                            begin
                                ptr_next   = idx_reg - 1'b1;
                                state_next = S_DOWN_RD;
                            end
                        end
                        else if (cflag_reg)
                        begin
                            dst_next   = idx_reg;
                            ptr_next   = idx_reg + 1'b1;
                            state_next = S_CH_RD;
                        end
                    end
                    default:
                    begin
                        // insert
                        if (rdata_reg == '0)
                        begin
                            mem_we = 1'b1;
                            mem_wd = item_reg;
                            if (item_reg != '0)
                            begin
                                occ_next = occ_reg + 1'b1;
                                if (idx_reg == end_reg)
                                    end_next = end_reg + 1'b1;
                            end
                        end
                        else
                            state_next = S_DECIDE;
                    end
                endcase
            end
            S_SWAP_EV:
            begin
                mem_we     = 1'b1;
                mem_wa     = IW'(idx_reg);
                mem_wd     = rdata_reg;
                state_next = S_SWAP_W2;
            end
            S_SWAP_W2:
            begin
                mem_we     = 1'b1;
                mem_wa     = IW'(idx2_reg);
                mem_wd     = a_reg;
                state_next = S_DONE;
            end
            // walk down to the last occupied slot below a removed end slot
            S_DOWN_RD:
            begin
                mem_ra     = IW'(ptr_reg);
                state_next = S_DOWN_EV;
            end
            S_DOWN_EV:
            begin
                if (rdata_reg != '0)
                begin
                    end_next   = ptr_reg + 1'b1;
                    state_next = S_DONE;
                end
                else if (ptr_reg == '0)
                begin
                    end_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    ptr_next   = ptr_reg - 1'b1;
                    state_next = S_DOWN_RD;
                end
            end
            S_DECIDE:
            begin
                hole_next = end_reg;
                ptr_next  = idx_reg + 1'b1;
                state_next = minimal ? S_HOLE_RD : S_CHECK;
            end
            // search for the first hole after the insert slot
            S_HOLE_RD:
            begin
                mem_ra = IW'(ptr_reg);
                if (ptr_reg >= end_reg)
                    state_next = S_CHECK;
                else
                    state_next = S_HOLE_EV;
            end
            S_HOLE_EV:
            begin
                if (rdata_reg == '0)
                begin
                    hole_next  = ptr_reg;
                    state_next = S_CHECK;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = S_HOLE_RD;
                end
            end
            S_CHECK:
            begin
                if (EW'(hole_reg) >= CAP_E)
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    ptr_next   = hole_reg;
                    state_next = S_SHIFT_RD;
                end
            end
            // shift entries down by one from the hole back to the insert slot
            S_SHIFT_RD:
            begin
                mem_ra = IW'(ptr_reg - 1'b1);
                if (ptr_reg == idx_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = IW'(idx_reg);
                    mem_wd = item_reg;
                    if (item_reg != '0)
                        occ_next = occ_reg + 1'b1;
                    if (hole_reg == end_reg)
                        end_next = end_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                    state_next = S_SHIFT_EV;
            end
            S_SHIFT_EV:
            begin
                mem_we     = 1'b1;
                mem_wa     = IW'(ptr_reg);
                mem_wd     = rdata_reg;
                ptr_next   = ptr_reg - 1'b1;
                state_next = S_SHIFT_RD;
            end
            // close holes: move occupied entries up to the write pointer
            S_CH_RD:
            begin
                mem_ra = IW'(ptr_reg);
                if (ptr_reg >= end_reg)
                begin
                    ptr_next   = dst_reg;
                    state_next = S_ZERO;
                end
                else
                    state_next = S_CH_EV;
            end
            S_CH_EV:
            begin
                if (rdata_reg != '0)
                begin
                    mem_we   = 1'b1;
                    mem_wa   = IW'(dst_reg);
                    mem_wd   = rdata_reg;
                    dst_next = dst_reg + 1'b1;
                end
                ptr_next   = ptr_reg + 1'b1;
                state_next = S_CH_RD;
            end
            // zero the vacated tail
            S_ZERO:
            begin
                if (ptr_reg >= end_reg)
                begin
                    end_next   = dst_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_we   = 1'b1;
                    mem_wa   = IW'(ptr_reg);
                    mem_wd   = '0;
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                done_next               = 1'b1;
                rsp_next.status         = status_reg;
                rsp_next.item_out       = 32'(old_reg);
                rsp_next.end_marker_out = 9'(end_reg);
                rsp_next.occupied_out   = 9'(occ_reg);
                state_next              = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            end_reg    <= '0;
            occ_reg    <= '0;
            done_reg   <= 1'b0;
            op_reg     <= REQ_ADD;
            idx_reg    <= '0;
            idx2_reg   <= '0;
            item_reg   <= '0;
            mode_reg   <= SHIFT_AUTO;
            cflag_reg  <= 1'b0;
            ptr_reg    <= '0;
            dst_reg    <= '0;
            hole_reg   <= '0;
            old_reg    <= '0;
            a_reg      <= '0;
            status_reg <= ST_OK;
            rsp_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            end_reg    <= end_next;
            occ_reg    <= occ_next;
            done_reg   <= done_next;
            op_reg     <= op_next;
            idx_reg    <= idx_next;
            idx2_reg   <= idx2_next;
            item_reg   <= item_next;
            mode_reg   <= mode_next;
            cflag_reg  <= cflag_next;
            ptr_reg    <= ptr_next;
            dst_reg    <= dst_next;
            hole_reg   <= hole_next;
            old_reg    <= old_next;
            a_reg      <= a_next;
            status_reg <= status_next;
            rsp_reg    <= rsp_next;
        end
    end

    // slot memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rdata_reg <= vld_reg[mem_ra] ? mem[mem_ra] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (mem_we)
            vld_reg[mem_wa] <= 1'b1;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_count_le_end: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= end_reg)
        else $error("occupied count above end marker");

    a_end_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(end_reg) <= CAP_E)
        else $error("end marker past capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_done_after_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == S_DONE && !busy))
        else $error("done strobe without finishing state");

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for sparse_slot_array_engine_unit
// directed table then phased random requests, checked by an in-bench model or typed rows
// depends on ssae_pkg and the design under test
module testbench;
    import ssae_pkg::*;

    localparam int CAP        = 256;
    localparam int IDLE_LIMIT = 20000;   // well above the slowest minimal insert
    localparam int TAIL_WAIT  = 50;

    // one row of the directed table: the request word and, where it is obvious,
    // the expected response word typed in by hand
    typedef struct {
        req_t req;
        bit   typed;
        rsp_t rsp;
    } row_t;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    // in-bench copy of the slot array
    logic [31:0] slot_img [CAP];
    int          img_end;
    int          img_count;

    rsp_t        rsp_q [$];
    int          mismatches;
    int          idle_cycles;
    bit          typed_now;
    rsp_t        typed_rsp;
    int          burst_left;

    sparse_slot_array_engine_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // pull the entries from scan onward up to from, zero the rest, move the end marker
    function automatic void close_holes(int from, int scan);
        int dst;
        dst = from;
        for (int i = scan; i < img_end; i++)
        begin
            if (slot_img[i] != 0)
            begin
                slot_img[dst] = slot_img[i];
                dst++;
            end
        end
        for (int i = dst; i < img_end; i++)
            slot_img[i] = '0;
        img_end = dst;
    endfunction

    // apply one request word to the slot array image and build the response word
    function automatic rsp_t apply_request(req_t r);
        rsp_t        o;
        logic [1:0]  st;
        logic [31:0] old;
        logic [31:0] tmp;
        int          idx;
        int          idx2;
        int          e;
        int          hole;
        int          i;
        bit          minimal;
        st   = ST_OK;
        old  = '0;
        idx  = r.slot_index;
        idx2 = r.second_index;
        e    = img_end;
        case (r.req_type)
            REQ_ADD:
            begin
                if (r.item_value == 0)
                    st = ST_EMPTY;
                else if (img_end >= CAP)
                    st = ST_FULL;
                else
                begin
                    slot_img[img_end] = r.item_value;
                    img_end++;
                    img_count++;
                end
            end
            REQ_INSERT:
            begin
                if (idx > e || r.shift_mode > SHIFT_FULL)
                    st = ST_BAD_INDEX;
                else if (idx >= CAP)
                    st = ST_FULL;
                else if (slot_img[idx] == 0)
                begin
                    // hole or end slot filled in place
                    slot_img[idx] = r.item_value;
                    if (r.item_value != 0)
                    begin
                        img_count++;
                        if (idx == e)
                            img_end = e + 1;
                    end
                end
                else
                begin
                    if (e == img_count)
                        minimal = 0;
                    else if (r.shift_mode == SHIFT_HOLE)
                        minimal = 1;
                    else if (r.shift_mode == SHIFT_FULL)
                        minimal = 0;
                    else if (e < AUTO_MIN_END)
                        minimal = 0;
                    else
                        minimal = (longint'(e - img_count) * longint'(e - idx)) >
                                  longint'(2 * e);
                    hole = e;
                    if (minimal)
                    begin
                        for (i = idx + 1; i < e; i++)
                        begin
                            if (slot_img[i] == 0)
                            begin
                                hole = i;
                                break;
                            end
                        end
                    end
                    if (hole >= CAP)
                        st = ST_FULL;
                    else
                    begin
                        for (i = hole; i > idx; i--)
                            slot_img[i] = slot_img[i - 1];
                        slot_img[idx] = r.item_value;
                        if (r.item_value != 0)
                            img_count++;
                        if (hole == e)
                            img_end = e + 1;
                    end
                end
            end
            REQ_REMOVE:
            begin
                if (idx >= img_end)
                    st = ST_BAD_INDEX;
                else
                begin
                    old = slot_img[idx];
                    if (old != 0)
                        img_count--;
                    slot_img[idx] = '0;
                    if (idx == img_end - 1)
                    begin
                        // end marker falls back to the last occupied slot
                        i = idx - 1;
                        while (i >= 0 && slot_img[i] == 0)
                            i--;
                        img_end = i + 1;
                    end
                    else if (r.compact_flag)
                        close_holes(idx, idx + 1);
                end
            end
            REQ_REPLACE:
            begin
                if (idx >= img_end)
                    st = ST_BAD_INDEX;
                else
                begin
                    old = slot_img[idx];
                    slot_img[idx] = r.item_value;
                    if (r.item_value == 0 && old != 0)
                        img_count--;
                    else if (r.item_value != 0 && old == 0)
                        img_count++;
                end
            end
            REQ_SWAP:
            begin
                if (idx != idx2)
                begin
                    if (idx >= img_end || idx2 >= img_end)
                        st = ST_BAD_INDEX;
                    else
                    begin
                        tmp            = slot_img[idx];
                        slot_img[idx]  = slot_img[idx2];
                        slot_img[idx2] = tmp;
                    end
                end
            end
            REQ_COMPACT:
                close_holes(0, 0);
            REQ_READ:
            begin
                if (idx >= img_end)
                    st = ST_BAD_INDEX;
                else
                    old = slot_img[idx];
            end
            default:
                st = ST_BAD_INDEX;
        endcase
        o.status         = st;
        o.item_out       = old;
        o.end_marker_out = img_end[8:0];
        o.occupied_out   = img_count[8:0];
        return o;
    endfunction

    function automatic req_t make_req(logic [2:0] op, logic [8:0] idx, logic [7:0] idx2,
                                      logic [31:0] val, logic [1:0] mode, logic cf);
        req_t r;
        r.req_type     = op;
        r.slot_index   = idx;
        r.second_index = idx2;
        r.item_value   = val;
        r.shift_mode   = mode;
        r.compact_flag = cf;
        return r;
    endfunction

    function automatic rsp_t make_rsp(logic [1:0] st, logic [31:0] item, int e, int cnt);
        rsp_t o;
        o.status         = st;
        o.item_out       = item;
        o.end_marker_out = e[8:0];
        o.occupied_out   = cnt[8:0];
        return o;
    endfunction

    // index mostly inside the used range, sometimes anywhere in the 9-bit field
    function automatic logic [8:0] pick_index();
        if ($urandom_range(0, 9) == 0 || img_end == 0)
            return 9'($urandom_range(0, 511));
        return 9'($urandom_range(0, img_end));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(1, 255));
        endcase
    endfunction

    // random request; add_pct steers between filling and draining the array
    function automatic req_t random_req(int add_pct, int remove_pct);
        req_t        r;
        int          roll;
        logic [2:0]  op;
        logic [7:0]  idx2;
        roll = $urandom_range(0, 99);
        if (roll < add_pct)
            op = REQ_ADD;
        else if (roll < add_pct + remove_pct)
            op = REQ_REMOVE;
        else
            op = 3'($urandom_range(1, 7));
        if ($urandom_range(0, 3) == 0 || img_end == 0)
            idx2 = 8'($urandom);
        else
            idx2 = 8'($urandom_range(0, img_end - 1));
        r = make_req(op, pick_index(), idx2, pick_value(),
                     ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                     1'($urandom));
        if (op == REQ_ADD && $urandom_range(0, 15) != 0 && r.item_value == 0)
            r.item_value = 32'd1;
        return r;
    endfunction

    // issue one word; the sender runs in bursts with random gaps between them
    task automatic send_word(req_t r, bit typed, rsp_t e);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        start     <= 1'b1;
        req       <= r;
        typed_now  = typed;
        typed_rsp  = e;
        // accepted at the first rising edge that sees busy low
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        wait (rsp_q.size() == 0);
    endtask

    // response checking against the oldest pending expectation, then capture of new words
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        bit   moved;
        moved = 1'b0;
        if (rst_n && done)
        begin
            moved = 1'b1;
            if (rsp_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response word: %p", rsp);
            end
            else
            begin
                exp_rsp = rsp_q.pop_front();
                if (rsp.status !== exp_rsp.status || rsp.item_out !== exp_rsp.item_out ||
                    rsp.end_marker_out !== exp_rsp.end_marker_out ||
                    rsp.occupied_out !== exp_rsp.occupied_out)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status %0d/%0d item %h/%h end %0d/%0d count %0d/%0d",
                                 exp_rsp.status, rsp.status, exp_rsp.item_out, rsp.item_out,
                                 exp_rsp.end_marker_out, rsp.end_marker_out,
                                 exp_rsp.occupied_out, rsp.occupied_out);
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            moved   = 1'b1;
            exp_rsp = apply_request(req);
            // hand-typed rows override the model
            if (typed_now)
                exp_rsp = typed_rsp;
            rsp_q.push_back(exp_rsp);
        end
        // watchdog on cycles where nothing moves
        if (moved)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        row_t table_rows [$];
        row_t row;
        rsp_t none;
        int   n_items;
        int   add_pct;
        int   rem_pct;
        none        = '0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        typed_now   = 1'b0;
        typed_rsp   = '0;
        mismatches  = 0;
        idle_cycles = 0;
        burst_left  = 0;
        img_end     = 0;
        img_count   = 0;
        for (int i = 0; i < CAP; i++)
            slot_img[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: error codes and small shifts from reset
        table_rows.push_back('{make_req(REQ_READ, 0, 0, 0, SHIFT_AUTO, 0), 1,
                               make_rsp(ST_BAD_INDEX, 0, 0, 0)});
        table_rows.push_back('{make_req(REQ_ADD, 0, 0, 0, SHIFT_AUTO, 0), 1,
                               make_rsp(ST_EMPTY, 0, 0, 0)});
        table_rows.push_back('{make_req(REQ_REMOVE, 0, 0, 0, SHIFT_AUTO, 1), 1,
                               make_rsp(ST_BAD_INDEX, 0, 0, 0)});
        table_rows.push_back('{make_req(3'd7, 9'h1FF, 8'hFF, 32'hFFFF_FFFF, 2'd3, 1), 1,
                               make_rsp(ST_BAD_INDEX, 0, 0, 0)});
        table_rows.push_back('{make_req(REQ_COMPACT, 0, 0, 0, SHIFT_AUTO, 0), 1,
                               make_rsp(ST_OK, 0, 0, 0)});
        table_rows.push_back('{make_req(REQ_ADD, 0, 0, 32'hFFFF_FFFF, SHIFT_AUTO, 0), 1,
                               make_rsp(ST_OK, 0, 1, 1)});
        table_rows.push_back('{make_req(REQ_ADD, 0, 0, 1, SHIFT_AUTO, 0), 1,
                               make_rsp(ST_OK, 0, 2, 2)});
        table_rows.push_back('{make_req(REQ_INSERT, 3, 0, 5, SHIFT_FULL, 0), 1,
                               make_rsp(ST_BAD_INDEX, 0, 2, 2)});
        table_rows.push_back('{make_req(REQ_INSERT, 0, 0, 5, 2'd3, 0), 1,
                               make_rsp(ST_BAD_INDEX, 0, 2, 2)});
        table_rows.push_back('{make_req(REQ_INSERT, 9'd256, 0, 5, SHIFT_FULL, 0), 1,
                               make_rsp(ST_BAD_INDEX, 0, 2, 2)});
        table_rows.push_back('{make_req(REQ_READ, 1, 0, 0, SHIFT_AUTO, 0), 1,
                               make_rsp(ST_OK, 1, 2, 2)});
        table_rows.push_back('{make_req(REQ_REPLACE, 1, 0, 0, SHIFT_AUTO, 0), 1,
                               make_rsp(ST_OK, 1, 2, 1)});
        table_rows.push_back('{make_req(REQ_INSERT, 1, 0, 5, SHIFT_HOLE, 0), 1,
                               make_rsp(ST_OK, 0, 2, 2)});
        table_rows.push_back('{make_req(REQ_SWAP, 0, 0, 0, SHIFT_AUTO, 0), 1,
                               make_rsp(ST_OK, 0, 2, 2)});
        table_rows.push_back('{make_req(REQ_SWAP, 0, 5, 0, SHIFT_AUTO, 0), 1,
                               make_rsp(ST_BAD_INDEX, 0, 2, 2)});
        table_rows.push_back('{make_req(REQ_SWAP, 9'h100, 0, 0, SHIFT_AUTO, 0), 1,
                               make_rsp(ST_BAD_INDEX, 0, 2, 2)});
        table_rows.push_back('{make_req(REQ_SWAP, 0, 1, 0, SHIFT_AUTO, 0), 0, none});
        table_rows.push_back('{make_req(REQ_INSERT, 0, 0, 7, SHIFT_FULL, 0), 0, none});
        table_rows.push_back('{make_req(REQ_INSERT, 1, 0, 9, SHIFT_HOLE, 0), 0, none});
        table_rows.push_back('{make_req(REQ_INSERT, 4, 0, 0, SHIFT_AUTO, 0), 0, none});
        table_rows.push_back('{make_req(REQ_REMOVE, 1, 0, 0, SHIFT_AUTO, 0), 0, none});
        table_rows.push_back('{make_req(REQ_REMOVE, 0, 0, 0, SHIFT_AUTO, 1), 0, none});
        table_rows.push_back('{make_req(REQ_REMOVE, 2, 0, 0, SHIFT_AUTO, 0), 0, none});
        table_rows.push_back('{make_req(REQ_COMPACT, 0, 0, 0, SHIFT_AUTO, 0), 0, none});
        foreach (table_rows[i])
        begin
            row = table_rows[i];
            send_word(row.req, row.typed, row.rsp);
        end
        drain_results();

        // random phases: mixed, fill past capacity, drain, mixed; sender waits out
        // every pending word between phases
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin n_items = 200; add_pct = 40; rem_pct = 15; end
                1:       begin n_items = 350; add_pct = 85; rem_pct = 2;  end
                2:       begin n_items = 200; add_pct = 5;  rem_pct = 60; end
                default: begin n_items = 250; add_pct = 35; rem_pct = 20; end
            endcase
            for (int k = 0; k < n_items; k++)
                send_word(random_req(add_pct, rem_pct), 1'b0, none);
            drain_results();
        end

        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0 && rsp_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ssae_pkg.sv
design/sparse_slot_array_engine_unit.sv
verif/testbench.sv
